// File: hdl/wpc_pkg.sv
// Package: shared types, codes and constants for the waypoint patrol heading controller.
`timescale 1ns / 1ps

package wpc_pkg;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE,
    S_NORM,
    S_EVT,
    S_RNORM,
    S_RDEC,
    S_RD,
    S_DIFF,
    S_SQX,
    S_SQY,
    S_SUM,
    S_SQRT,
    S_CINIT,
    S_CORD,
    S_ERR,
    S_YAWM,
    S_CLM,
    S_DIVS,
    S_DIVW,
    S_FIN,
    S_OUT0,
    S_OUT1
  } state_t;

  // Item operations
  localparam logic OP_STEP  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  // Event codes
  localparam logic [1:0] EV_NONE  = 2'd0;
  localparam logic [1:0] EV_FOUND = 2'd1;
  localparam logic [1:0] EV_ENDED = 2'd2;

  // Register indexes
  localparam logic [2:0] REG_YAW_GAIN  = 3'd0;
  localparam logic [2:0] REG_CRUISE    = 3'd1;
  localparam logic [2:0] REG_THRESHOLD = 3'd2;
  localparam logic [2:0] REG_RADIUS    = 3'd3;
  localparam logic [2:0] REG_COUNT     = 3'd4;

  // Angles
  localparam int PI_Q13      = 25736;
  localparam int TWO_PI_Q13  = 51472;
  localparam int HALF_PI_Q16 = 102944;

  // Iteration counts
  localparam int SQRT_STEPS   = 25;
  localparam int CORDIC_STEPS = 17;
  localparam int DIV_BITS     = 39;
  localparam int DIVISOR_BITS = 25;

  // atan(2^-i) in Q.16 radians
  function automatic logic [16:0] atan_q16(input logic [4:0] i);
    logic [16:0] a;
    unique case (i)
      5'd0:    a = 17'd51472;
      5'd1:    a = 17'd30386;
      5'd2:    a = 17'd16055;
      5'd3:    a = 17'd8150;
      5'd4:    a = 17'd4091;
      5'd5:    a = 17'd2047;
      5'd6:    a = 17'd1024;
      5'd7:    a = 17'd512;
      5'd8:    a = 17'd256;
      5'd9:    a = 17'd128;
      5'd10:   a = 17'd64;
      5'd11:   a = 17'd32;
      5'd12:   a = 17'd16;
      5'd13:   a = 17'd8;
      5'd14:   a = 17'd4;
      5'd15:   a = 17'd2;
      5'd16:   a = 17'd1;
      default: a = 17'd0;
    endcase
    return a;
  endfunction

endpackage

// File: hdl/wpc_div.sv
// Serial restoring divider: unsigned 39-bit dividend by 25-bit divisor, one bit a cycle.
`timescale 1ns / 1ps

module wpc_div
  import wpc_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [DIV_BITS-1:0]     dividend,
  input  logic [DIVISOR_BITS-1:0] divisor,
  output logic                    busy,
  output logic                    done,
  output logic [DIV_BITS-1:0]     quotient
);

  logic [DIVISOR_BITS-1:0] rem;
  logic [DIVISOR_BITS:0]   rem_sh;
  logic [DIVISOR_BITS:0]   rem_sub;
  logic                    ge;
  logic [5:0]              cnt;

  assign rem_sh  = {rem, quotient[DIV_BITS-1]};
  assign rem_sub = rem_sh - {1'b0, divisor};
  assign ge      = rem_sh >= {1'b0, divisor};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'(DIV_BITS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quotient <= dividend;
      rem      <= '0;
      cnt      <= '0;
    end else if (busy) begin
      rem      <= ge ? rem_sub[DIVISOR_BITS-1:0] : rem_sh[DIVISOR_BITS-1:0];
      quotient <= {quotient[DIV_BITS-2:0], ge};
      cnt      <= cnt + 6'd1;
    end
  end

endmodule

// File: hdl/waypoint_patrol_heading_controller_core.sv
// Top level: waypoint patrol heading controller with a sequenced shared datapath.
`timescale 1ns / 1ps
//
// Channel      | Handshake                       | Carries
// -------------+---------------------------------+-----------------------------------
// item in      | in_valid / in_ready             | operation, event, pose, waypoint
// result out   | out_valid / out_ready           | commands, reached, target_slot, last
// config       | psel, penable, pwrite, pready   | five registers at byte address 4*i
//
// A waypoint write is stored on acceptance while the sequencer stays in S_IDLE. A
// control step runs through the 25-step square root, the 17-step CORDIC and the
// divider wait to the load of its result, and on arrival a stop result follows.
// At zero distance the divider is skipped. A resume adds S_RNORM and S_RDEC, and
// each subtraction that brings the target index below a reduced waypoint count
// adds a pass through S_NORM or S_RNORM. A halted step goes from S_EVT to S_OUT0.
// Reset is synchronous and restores the registers, indexes and held commands;
// the waypoint table is left as it is. The sequencer waits in the output states
// while the result register is full and out_ready is low.

module waypoint_patrol_heading_controller_core
  import wpc_pkg::*;
#(
  parameter int MAX_WAYPOINTS = 8
) (
  input  logic               clk,
  input  logic               rst,
  // item channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               operation,
  input  logic [1:0]         event_req,
  input  logic signed [23:0] pos_x,
  input  logic signed [23:0] pos_y,
  input  logic signed [23:0] pos_z,
  input  logic signed [15:0] heading,
  input  logic [2:0]         slot,
  input  logic signed [23:0] way_x,
  input  logic signed [23:0] way_y,
  input  logic signed [23:0] way_z,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [15:0] vel_forward,
  output logic signed [15:0] vel_up,
  output logic signed [15:0] yaw_rate,
  output logic               reached,
  output logic [2:0]         target_slot,
  output logic               last,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  localparam int IW = $clog2(MAX_WAYPOINTS);
  localparam int CW = $clog2(MAX_WAYPOINTS + 1);

  state_t state, state_next;

  // configuration registers
  logic [15:0] yaw_gain;
  logic [14:0] cruise_speed;
  logic [14:0] heading_threshold;
  logic [15:0] arrive_radius;
  logic [3:0]  waypoint_count;

  // control state
  logic [IW-1:0]      target_index;
  logic [IW-1:0]      saved_index;
  logic               halted;
  logic               resume_pending;
  logic signed [15:0] held_forward;
  logic signed [15:0] held_up;
  logic signed [15:0] held_yaw_rate;

  // waypoint table
  logic signed [23:0] wp_x [MAX_WAYPOINTS];
  logic signed [23:0] wp_y [MAX_WAYPOINTS];
  logic signed [23:0] wp_z [MAX_WAYPOINTS];
  logic signed [23:0] rd_x, rd_y, rd_z;

  // latched item
  logic [1:0]         ev;
  logic signed [23:0] px, py, pz;
  logic signed [15:0] hd;

  // datapath
  logic signed [24:0] dx, dy, dz;
  logic signed [24:0] mul_a, mul_b;
  logic signed [49:0] prod;
  logic [49:0]        d2;
  logic [27:0]        rem;
  logic [24:0]        root;
  logic [4:0]         iter;
  logic signed [27:0] cx, cy;
  logic signed [19:0] cz;
  logic signed [17:0] err;
  logic signed [15:0] yaw_c;
  logic               climb_neg;
  logic               arr;

  // handshake helpers
  logic in_acc;
  logic out_load;
  logic cfg_wr;
  logic div_start, div_busy, div_done;
  logic [DIV_BITS-1:0] div_quo;

  // ---------------------------------------------------------------------------
  // Effective waypoint count, clamped to [1, MAX_WAYPOINTS]
  // ---------------------------------------------------------------------------
  logic [CW-1:0] cnt_eff;
  logic          tgt_ge;
  logic [IW-1:0] tgt_red;
  logic [IW-1:0] tgt_dec;
  logic [IW-1:0] tgt_adv;

  always_comb begin
    if (waypoint_count == 4'd0) begin
      cnt_eff = CW'(1);
    end else if (32'(waypoint_count) > MAX_WAYPOINTS) begin
      cnt_eff = CW'(MAX_WAYPOINTS);
    end else begin
      cnt_eff = CW'(waypoint_count);
    end
  end

  assign tgt_ge  = CW'(target_index) >= cnt_eff;
  assign tgt_red = IW'(CW'(target_index) - cnt_eff);
  assign tgt_dec = (target_index == '0) ? IW'(cnt_eff - CW'(1)) : target_index - IW'(1);
  assign tgt_adv = (CW'(target_index) + CW'(1) == cnt_eff) ? '0 : target_index + IW'(1);

  // Event resolution on a step
  logic halted_after;
  logic resume_after;

  assign halted_after = (ev == EV_FOUND) || (halted && ev != EV_ENDED);
  assign resume_after = resume_pending || (ev == EV_ENDED && halted);

  // ---------------------------------------------------------------------------
  // Square root step: one result bit per cycle
  // ---------------------------------------------------------------------------
  logic [27:0] rem_sh, trial;
  logic        sq_ge;

  assign rem_sh = {rem[25:0], d2[49:48]};
  assign trial  = {1'b0, root, 2'b01};
  assign sq_ge  = rem_sh >= trial;

  // ---------------------------------------------------------------------------
  // CORDIC vectoring step
  // ---------------------------------------------------------------------------
  logic signed [27:0] cx_sh, cy_sh;
  logic signed [19:0] ang;

  assign cx_sh = cx >>> iter;
  assign cy_sh = cy >>> iter;
  assign ang   = $signed({3'b000, atan_q16(iter)});

  // Bearing rounded to Q3.13 and heading error wrapped once
  logic signed [19:0] bsum;
  logic signed [16:0] bear;
  logic signed [17:0] err_raw, err_wrap, err_abs;

  assign bsum = cz + 20'sd4;
  assign bear = (dx == '0 && dy == '0) ? '0 : 17'(bsum >>> 3);
  assign err_raw = {bear[16], bear} - 18'(hd);

  always_comb begin
    if (err_raw > $signed(18'(PI_Q13))) begin
      err_wrap = err_raw - $signed(18'(TWO_PI_Q13));
    end else if (err_raw < -$signed(18'(PI_Q13))) begin
      err_wrap = err_raw + $signed(18'(TWO_PI_Q13));
    end else begin
      err_wrap = err_raw;
    end
  end

  assign err_abs = err[17] ? -err : err;

  // Yaw command: round the Q.25 product to Q3.12 and saturate
  logic signed [49:0] ysh;
  logic signed [15:0] yaw_sat;

  assign ysh = (prod + 50'sd4096) >>> 13;

  always_comb begin
    if (ysh > 50'sd32767) begin
      yaw_sat = 16'sd32767;
    end else if (ysh < -50'sd32768) begin
      yaw_sat = -16'sd32768;
    end else begin
      yaw_sat = 16'(ysh);
    end
  end

  // Climb command from the divider magnitude
  logic signed [49:0] prod_abs;
  logic signed [15:0] climb_val;

  assign prod_abs = prod[49] ? -prod : prod;

  always_comb begin
    if (root == '0) begin
      climb_val = '0;
    end else if (climb_neg) begin
      climb_val = (div_quo > DIV_BITS'(32768)) ? -16'sd32768 : 16'(-{1'b0, div_quo[15:0]});
    end else begin
      climb_val = (div_quo > DIV_BITS'(32767)) ? 16'sd32767 : 16'(div_quo[15:0]);
    end
  end

  // ---------------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:  if (in_acc && operation == OP_STEP) state_next = S_NORM;
      S_NORM:  if (!tgt_ge) state_next = S_EVT;
      S_EVT: begin
        if (halted_after) begin
          state_next = S_OUT0;
        end else if (resume_after) begin
          state_next = S_RNORM;
        end else begin
          state_next = S_RD;
        end
      end
      S_RNORM: if (!tgt_ge) state_next = S_RDEC;
      S_RDEC:  state_next = S_RD;
      S_RD:    state_next = S_DIFF;
      S_DIFF:  state_next = S_SQX;
      S_SQX:   state_next = S_SQY;
      S_SQY:   state_next = S_SUM;
      S_SUM:   state_next = S_SQRT;
      S_SQRT:  if (iter == 5'(SQRT_STEPS - 1)) state_next = S_CINIT;
      S_CINIT: state_next = S_CORD;
      S_CORD:  if (iter == 5'(CORDIC_STEPS - 1)) state_next = S_ERR;
      S_ERR:   state_next = S_YAWM;
      S_YAWM:  state_next = S_CLM;
      S_CLM:   state_next = S_DIVS;
      S_DIVS:  state_next = (root == '0) ? S_FIN : S_DIVW;
      S_DIVW:  if (div_done) state_next = S_FIN;
      S_FIN:   state_next = S_OUT0;
      S_OUT0:  if (out_load) state_next = arr ? S_OUT1 : S_IDLE;
      S_OUT1:  if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Sequencer: outputs and shared multiplier operand select
  // ---------------------------------------------------------------------------
  always_comb begin
    in_ready  = 1'b0;
    out_load  = 1'b0;
    div_start = 1'b0;
    mul_a     = '0;
    mul_b     = '0;
    unique case (state)
      S_IDLE:  in_ready = 1'b1;
      S_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      S_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      S_YAWM: begin
        mul_a = $signed({9'b0, yaw_gain});
        mul_b = 25'(err);
      end
      S_CLM: begin
        mul_a = $signed({10'b0, cruise_speed});
        mul_b = dz;
      end
      S_DIVS:  div_start = (root != '0);
      S_OUT0, S_OUT1: out_load = !out_valid || out_ready;
      default: ;
    endcase
  end

  assign in_acc = in_valid && in_ready;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  // ---------------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      yaw_gain          <= 16'd4096;
      cruise_speed      <= 15'd768;
      heading_threshold <= 15'd819;
      arrive_radius     <= 16'd256;
      waypoint_count    <= 4'd1;
      target_index      <= '0;
      saved_index       <= '0;
      halted            <= 1'b0;
      resume_pending    <= 1'b0;
      held_forward      <= '0;
      held_up           <= '0;
      held_yaw_rate     <= '0;
      out_valid         <= 1'b0;
    end else begin
      state <= state_next;

      // config transaction
      if (cfg_wr) begin
        unique case (paddr[4:2])
          REG_YAW_GAIN:  yaw_gain          <= pwdata[15:0];
          REG_CRUISE:    cruise_speed      <= pwdata[14:0];
          REG_THRESHOLD: heading_threshold <= pwdata[14:0];
          REG_RADIUS:    arrive_radius     <= pwdata[15:0];
          REG_COUNT:     waypoint_count    <= pwdata[3:0];
          default: ;
        endcase
      end

      // result register
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_NORM, S_RNORM: begin
          if (tgt_ge) target_index <= tgt_red;
        end
        S_EVT: begin
          if (ev == EV_FOUND) saved_index <= target_index;
          halted         <= halted_after;
          resume_pending <= halted_after ? resume_pending : 1'b0;
          if (halted_after) begin
            // halt: drop every command
            held_forward  <= '0;
            held_up       <= '0;
            held_yaw_rate <= '0;
          end else if (resume_after) begin
            target_index <= saved_index;
          end
        end
        S_RDEC: target_index <= tgt_dec;
        S_FIN: begin
          held_up <= climb_val;
          if (err_abs > $signed({3'b000, heading_threshold})) begin
            held_yaw_rate <= yaw_c;
          end else begin
            held_forward <= $signed({1'b0, cruise_speed});
          end
        end
        S_OUT0: begin
          // arrival: stop and advance to the next waypoint
          if (out_load && arr) begin
            held_forward <= '0;
            held_up      <= '0;
            target_index <= tgt_adv;
          end
        end
        default: ;
      endcase
    end
  end

  // config readback
  always_comb begin
    unique case (paddr[4:2])
      REG_YAW_GAIN:  prdata = {16'b0, yaw_gain};
      REG_CRUISE:    prdata = {17'b0, cruise_speed};
      REG_THRESHOLD: prdata = {17'b0, heading_threshold};
      REG_RADIUS:    prdata = {16'b0, arrive_radius};
      REG_COUNT:     prdata = {28'b0, waypoint_count};
      default:       prdata = '0;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Waypoint table: write on a write item, registered read of the target
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (in_acc && operation == OP_WRITE && 32'(slot) < MAX_WAYPOINTS) begin
      wp_x[IW'(slot)] <= way_x;
      wp_y[IW'(slot)] <= way_y;
      wp_z[IW'(slot)] <= way_z;
    end
    if (state == S_RD) begin
      rd_x <= wp_x[target_index];
      rd_y <= wp_y[target_index];
      rd_z <= wp_z[target_index];
    end
  end

  // ---------------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;

    if (out_load) begin
      vel_forward <= held_forward;
      vel_up      <= held_up;
      yaw_rate    <= held_yaw_rate;
      reached     <= (state == S_OUT1);
      target_slot <= 3'(target_index);
      last        <= (state == S_OUT1) || !arr;
    end

    unique case (state)
      S_IDLE: begin
        if (in_acc) begin
          ev <= event_req;
          px <= pos_x;
          py <= pos_y;
          pz <= pos_z;
          hd <= heading;
        end
      end
      S_EVT: arr <= 1'b0;
      S_DIFF: begin
        dx <= {rd_x[23], rd_x} - {px[23], px};
        dy <= {rd_y[23], rd_y} - {py[23], py};
        dz <= {rd_z[23], rd_z} - {pz[23], pz};
      end
      S_SQY: d2 <= 50'(prod);
      S_SUM: begin
        d2   <= d2 + 50'(prod);
        rem  <= '0;
        root <= '0;
        iter <= '0;
      end
      S_SQRT: begin
        rem  <= sq_ge ? rem_sh - trial : rem_sh;
        root <= {root[23:0], sq_ge};
        d2   <= {d2[47:0], 2'b00};
        iter <= iter + 5'd1;
      end
      S_CINIT: begin
        iter <= '0;
        // quarter-turn pre-rotation into the right half plane
        if (dx[24]) begin
          if (!dy[24]) begin
            cx <= 28'(dy);
            cy <= -28'(dx);
            cz <= 20'(HALF_PI_Q16);
          end else begin
            cx <= -28'(dy);
            cy <= 28'(dx);
            cz <= -20'(HALF_PI_Q16);
          end
        end else begin
          cx <= 28'(dx);
          cy <= 28'(dy);
          cz <= '0;
        end
      end
      S_CORD: begin
        iter <= iter + 5'd1;
        if (cy > 28'sd0) begin
          cx <= cx + cy_sh;
          cy <= cy - cx_sh;
          cz <= cz + ang;
        end else begin
          cx <= cx - cy_sh;
          cy <= cy + cx_sh;
          cz <= cz - ang;
        end
      end
      S_ERR:  err <= err_wrap;
      S_CLM:  yaw_c <= yaw_sat;
      S_DIVS: climb_neg <= prod[49];
      S_FIN:  arr <= root < {9'b0, arrive_radius};
      default: ;
    endcase
  end

  // ---------------------------------------------------------------------------
  // Climb divider
  // ---------------------------------------------------------------------------
  wpc_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (prod_abs[DIV_BITS-1:0]),
    .divisor  (root),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quo)
  );

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  a_halt_zero: assert property (@(posedge clk) disable iff (rst)
    halted |-> (held_forward == '0 && held_up == '0 && held_yaw_rate == '0))
    else $error("held commands not zero while halted");

  a_reached_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && reached) |-> last)
    else $error("arrival result not marked last");

  a_div_state: assert property (@(posedge clk) disable iff (rst)
    div_busy |-> state == S_DIVW)
    else $error("divider busy outside its wait state");

  a_second_needs_arrival: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT1) |-> arr)
    else $error("second result without arrival");

endmodule

// File: dv/tb_waypoint_patrol_heading_controller_core.sv
// Testbench: checks the waypoint patrol heading controller against its own predictor.
`timescale 1ns / 1ps

module tb_waypoint_patrol_heading_controller_core
  import wpc_pkg::*;
();

  localparam int NWAY = 8;
  localparam longint CYCLE_LIMIT = 2000000;

  logic clk, rst;
  logic in_valid, in_ready;
  logic operation;
  logic [1:0] event_req;
  logic signed [23:0] pos_x, pos_y, pos_z;
  logic signed [15:0] heading;
  logic [2:0] slot;
  logic signed [23:0] way_x, way_y, way_z;
  logic out_valid, out_ready;
  logic signed [15:0] vel_forward, vel_up, yaw_rate;
  logic reached, last;
  logic [2:0] target_slot;
  logic psel, penable, pwrite, pready;
  logic [4:0] paddr;
  logic [31:0] pwdata, prdata;

  waypoint_patrol_heading_controller_core DUT (.*);

  // One expected command transaction
  typedef struct packed {
    logic signed [15:0] fwd;
    logic signed [15:0] up;
    logic signed [15:0] yaw;
    logic               rch;
    logic [2:0]         tslot;
    logic               lst;
  } command_t;

  command_t expected_cmds[$];
  int mismatches = 0;
  longint cycle_count = 0;
  bit calm = 0;  // when set, both sides stop idling

  // Predictor state
  int way_tx[NWAY], way_ty[NWAY], way_tz[NWAY];
  int tgt_idx, sv_idx;
  bit is_halted, resume_pend;
  int hold_fwd, hold_up, hold_yaw;
  int p_gain, p_cruise, p_thresh, p_radius, p_count;

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Count cycles and end the run if it stalls
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what);
    mismatches++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Append one expected transaction at the tail of the queue
  task automatic queue_cmd(input command_t c);
    expected_cmds.insert(expected_cmds.size(), c);
  endtask

  function automatic longint floor_shift(input longint v, input int s);
    if (v >= 0) return v >>> s;
    return -((((-v) - 1) >>> s) + 1);
  endfunction

  function automatic int clip16(input longint v);
    if (v > 32767) return 32767;
    if (v < -32768) return -32768;
    return int'(v);
  endfunction

  function automatic longint int_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return longint'(r);
  endfunction

  // CORDIC vectoring bearing in Q3.13
  function automatic longint bearing(input longint dx, input longint dy);
    longint x, y, z, t;
    if (dx == 0 && dy == 0) return 0;
    x = dx; y = dy; z = 0;
    if (dx < 0) begin
      if (dy >= 0) begin
        x = dy; y = -dx; z = HALF_PI_Q16;
      end else begin
        x = -dy; y = dx; z = -HALF_PI_Q16;
      end
    end
    for (int i = 0; i < 17; i++) begin
      t = x;
      if (y > 0) begin
        x += floor_shift(y, i); y -= floor_shift(t, i); z += atan_q16(5'(i));
      end else begin
        x -= floor_shift(y, i); y += floor_shift(t, i); z -= atan_q16(5'(i));
      end
    end
    return floor_shift(z + 4, 3);
  endfunction

  function automatic command_t pack_cmd(input bit r, input bit l);
    command_t c;
    c.fwd = hold_fwd[15:0]; c.up = hold_up[15:0]; c.yaw = hold_yaw[15:0];
    c.rch = r; c.tslot = tgt_idx[2:0]; c.lst = l;
    return c;
  endfunction

  // Advance the predictor by one item and queue the commands it produces
  task automatic predict_commands(input bit op, input logic [1:0] ev, input int px,
                                  input int py, input int pz, input int hd,
                                  input int sl, input int wx, input int wy, input int wz);
    int cnt;
    longint dx, dy, dz, err, gap, climb;
    longint unsigned d2;
    if (op == OP_WRITE) begin
      way_tx[sl] = wx; way_ty[sl] = wy; way_tz[sl] = wz;
      return;
    end
    cnt = p_count < 1 ? 1 : (p_count > NWAY ? NWAY : p_count);
    tgt_idx = tgt_idx % cnt;
    if (ev == EV_FOUND) begin
      is_halted = 1; sv_idx = tgt_idx;
    end else if (ev == EV_ENDED && is_halted) begin
      is_halted = 0; resume_pend = 1;
    end
    if (is_halted) begin
      hold_fwd = 0; hold_up = 0; hold_yaw = 0;
      queue_cmd(pack_cmd(0, 1));
      return;
    end
    if (resume_pend) begin
      resume_pend = 0;
      tgt_idx = (sv_idx % cnt + cnt - 1) % cnt;
    end
    dx = longint'(way_tx[tgt_idx]) - px;
    dy = longint'(way_ty[tgt_idx]) - py;
    dz = longint'(way_tz[tgt_idx]) - pz;
    d2 = longint'(dx * dx) + longint'(dy * dy);
    gap = int_sqrt(d2);
    err = bearing(dx, dy) - hd;
    if (err > PI_Q13) err -= TWO_PI_Q13;
    else if (err < -PI_Q13) err += TWO_PI_Q13;
    climb = 0;
    if (gap != 0) climb = clip16((longint'(p_cruise) * dz) / gap);
    if ((err < 0 ? -err : err) > p_thresh) begin
      hold_yaw = clip16(floor_shift(longint'(p_gain) * err + 4096, 13));
    end else begin
      hold_fwd = p_cruise;
    end
    hold_up = int'(climb);
    if (d2 < longint'(p_radius) * p_radius) begin
      queue_cmd(pack_cmd(0, 0));
      hold_fwd = 0; hold_up = 0;
      tgt_idx = (tgt_idx + 1) % cnt;
      queue_cmd(pack_cmd(1, 1));
    end else begin
      queue_cmd(pack_cmd(0, 1));
    end
  endtask

  // Drive one item, hold it until accepted, then update the predictor
  task automatic send_item(input bit op, input logic [1:0] ev, input int px, input int py,
                           input int pz, input int hd, input int sl, input int wx,
                           input int wy, input int wz);
    if (!calm && $urandom_range(99) < 25) begin
      in_valid <= 0;
      do @(posedge clk); while ($urandom_range(99) < 25);
    end
    in_valid <= 1;
    operation <= op; event_req <= ev;
    pos_x <= px[23:0]; pos_y <= py[23:0]; pos_z <= pz[23:0]; heading <= hd[15:0];
    slot <= sl[2:0]; way_x <= wx[23:0]; way_y <= wy[23:0]; way_z <= wz[23:0];
    do @(posedge clk); while (!in_ready);
    predict_commands(op, ev, px, py, pz, hd, sl, wx, wy, wz);
  endtask

  task automatic drain;
    in_valid <= 0;
    while (expected_cmds.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
  endtask

  // Register write over the config port, only while the block is idle
  task automatic write_reg(input logic [2:0] idx, input int val);
    drain();
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_YAW_GAIN:  p_gain = val & 16'hFFFF;
      REG_CRUISE:    p_cruise = val & 16'h7FFF;
      REG_THRESHOLD: p_thresh = val & 16'h7FFF;
      REG_RADIUS:    p_radius = val & 16'hFFFF;
      REG_COUNT:     p_count = val & 4'hF;
      default: ;
    endcase
  endtask

  // Check each accepted result against the oldest expectation
  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      command_t e;
      if (expected_cmds.size() == 0) begin
        report_mismatch("result with nothing expected");
      end else begin
        e = expected_cmds.pop_front();
        if (vel_forward !== e.fwd)
          report_mismatch($sformatf("vel_forward %0d exp %0d", vel_forward, e.fwd));
        if (vel_up !== e.up)
          report_mismatch($sformatf("vel_up %0d exp %0d", vel_up, e.up));
        if (yaw_rate !== e.yaw)
          report_mismatch($sformatf("yaw_rate %0d exp %0d", yaw_rate, e.yaw));
        if (reached !== e.rch)
          report_mismatch($sformatf("reached %0b exp %0b", reached, e.rch));
        if (target_slot !== e.tslot)
          report_mismatch($sformatf("target_slot %0d exp %0d", target_slot, e.tslot));
        if (last !== e.lst)
          report_mismatch($sformatf("last %0b exp %0b", last, e.lst));
      end
    end
  end

  // Stall the result side at random
  always @(posedge clk) begin
    if (rst) out_ready <= 0;
    else out_ready <= calm || ($urandom_range(99) >= 25);
  end

  function automatic int sx24(input logic [23:0] v);
    return int'(signed'(v));
  endfunction

  function automatic int near(input int c, input int span);
    longint v;
    v = longint'(c) + $signed($urandom_range(2 * span)) - span;
    if (v > 8388607) v = 8388607;
    if (v < -8388608) v = -8388608;
    return int'(v);
  endfunction

  function automatic int rand_heading();
    return int'($urandom_range(51472)) - 25736;
  endfunction

  // Fill every table slot so no step reads an unwritten entry
  task automatic test_table_fill();
    for (int s = 0; s < NWAY; s++)
      send_item(OP_WRITE, 2'($urandom), sx24(24'($urandom)), sx24(24'($urandom)), 0, 0, s,
                int'($urandom_range(4000)) - 2000, int'($urandom_range(4000)) - 2000,
                int'($urandom_range(1000)) - 500);
  endtask

  // Extremes of pose and waypoint fields, zero distance, wraparound of heading error
  task automatic test_directed_extremes();
    send_item(OP_WRITE, EV_NONE, 0, 0, 0, 0, 0, 8388607, -8388608, 8388607);
    send_item(OP_STEP, EV_NONE, -8388608, 8388607, -8388608, 25736, 0, 0, 0, 0);
    send_item(OP_STEP, EV_NONE, 8388607, -8388608, 8388607, -25736, 0, 0, 0, 0);
    send_item(OP_STEP, EV_NONE, 8388607, -8388608, 8388607, 0, 0, 0, 0, 0);  // zero distance
    send_item(OP_WRITE, EV_NONE, 0, 0, 0, 0, 0, -8388608, 8388607, -8388608);
    send_item(OP_STEP, EV_NONE, 8388607, -8388608, 8388607, -25736, 0, 0, 0, 0);
    send_item(OP_STEP, EV_NONE, 0, 0, 0, 25736, 0, 0, 0, 0);
    send_item(OP_STEP, 2'd3, 0, 0, 0, 0, 0, 0, 0, 0);  // unused event code
    send_item(OP_WRITE, EV_NONE, 0, 0, 0, 0, 0, 100, 0, 50);
    send_item(OP_STEP, EV_NONE, 0, 0, 0, 0, 0, 0, 0, 0);  // arrival, straight ahead
  endtask

  // Halt on target found, stay halted, resume one waypoint back
  task automatic test_halt_resume();
    send_item(OP_STEP, EV_ENDED, 10, 10, 0, 0, 0, 0, 0, 0);  // ended while not halted
    send_item(OP_STEP, EV_FOUND, 10, 10, 0, 0, 0, 0, 0, 0);
    send_item(OP_STEP, EV_NONE, 10, 10, 0, 0, 0, 0, 0, 0);
    send_item(OP_STEP, EV_FOUND, 10, 10, 0, 0, 0, 0, 0, 0);
    send_item(OP_STEP, EV_ENDED, 10, 10, 0, 1000, 0, 0, 0, 0);
    send_item(OP_STEP, EV_NONE, 500, -300, 0, -1000, 0, 0, 0, 0);
  endtask

  // Random patrol: mostly steps near the current target, some events and rewrites
  task automatic test_random_patrol(input int n);
    int t, cx, cy, cz;
    for (int i = 0; i < n; i++) begin
      if (i == n / 3) calm = 1;
      if (i == n / 3 + 150) calm = 0;
      t = tgt_idx % NWAY;
      cx = way_tx[t]; cy = way_ty[t]; cz = way_tz[t];
      case ($urandom_range(19))
        0: send_item(OP_WRITE, 2'($urandom), sx24(24'($urandom)), 0, 0, 0,
                     $urandom_range(7), sx24(24'($urandom)), sx24(24'($urandom)),
                     sx24(24'($urandom)));
        1: send_item(OP_STEP, EV_FOUND, near(cx, 500), near(cy, 500), near(cz, 500),
                     rand_heading(), 0, 0, 0, 0);
        2: send_item(OP_STEP, EV_ENDED, near(cx, 500), near(cy, 500), near(cz, 500),
                     rand_heading(), 0, 0, 0, 0);
        3: send_item(OP_STEP, 2'($urandom), sx24(24'($urandom)), sx24(24'($urandom)),
                     sx24(24'($urandom)), sx24(24'($urandom)) >>> 8, 0, 0, 0, 0);
        default: send_item(OP_STEP, EV_NONE, near(cx, 600), near(cy, 600),
                           near(cz, 3000), rand_heading(), 0, 0, 0, 0);
      endcase
      if (i == n / 2) drain();  // let every pending result arrive before continuing
    end
  endtask

  // Register sweeps, extremes included, with a random patrol under each setting
  task automatic test_register_settings();
    write_reg(REG_COUNT, 8);
    write_reg(REG_RADIUS, 400);
    test_random_patrol(400);
    write_reg(REG_YAW_GAIN, 65535);
    write_reg(REG_CRUISE, 32767);
    write_reg(REG_THRESHOLD, 0);
    write_reg(REG_RADIUS, 65535);
    write_reg(REG_COUNT, 3);
    test_random_patrol(150);
    write_reg(REG_YAW_GAIN, 0);
    write_reg(REG_CRUISE, 0);
    write_reg(REG_THRESHOLD, 25736);
    write_reg(REG_RADIUS, 0);
    write_reg(REG_COUNT, 15);  // clamps to the table size
    test_random_patrol(150);
    write_reg(REG_COUNT, 0);   // clamps to one
    write_reg(REG_RADIUS, 300);
    test_random_patrol(100);
    write_reg(REG_YAW_GAIN, $urandom_range(65535));
    write_reg(REG_CRUISE, $urandom_range(32767));
    write_reg(REG_THRESHOLD, $urandom_range(25736));
    write_reg(REG_RADIUS, $urandom_range(800));
    write_reg(REG_COUNT, $urandom_range(1, 8));
    test_random_patrol(450);
  endtask

  initial begin
    rst = 1;
    in_valid = 0; operation = OP_STEP; event_req = EV_NONE;
    pos_x = 0; pos_y = 0; pos_z = 0; heading = 0; slot = 0;
    way_x = 0; way_y = 0; way_z = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    tgt_idx = 0; sv_idx = 0; is_halted = 0; resume_pend = 0;
    hold_fwd = 0; hold_up = 0; hold_yaw = 0;
    p_gain = 4096; p_cruise = 768; p_thresh = 819; p_radius = 256; p_count = 1;
    for (int s = 0; s < NWAY; s++) begin
      way_tx[s] = 0; way_ty[s] = 0; way_tz[s] = 0;
    end
    repeat (9) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    test_table_fill();
    test_directed_extremes();
    test_halt_resume();
    test_register_settings();
    drain();
    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
